// File: hdl/sxo_pkg.sv
`default_nettype none

package sxo_pkg;

    // command codes
    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_EVAL   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT = 3'd1;
    localparam logic [2:0] ST_FEW_ENDS  = 3'd2;
    localparam logic [2:0] ST_SAME_REG  = 3'd3;
    localparam logic [2:0] ST_PREFIX    = 3'd4;
    localparam logic [2:0] ST_SUFFIX    = 3'd5;

    // configuration register indexes
    localparam logic REG_MIN_OVERLAP = 1'b0;
    localparam logic REG_SEED_LENGTH = 1'b1;

    localparam logic [10:0] MIN_OVERLAP_RESET = 11'd25;
    localparam logic [7:0]  SEED_LENGTH_RESET = 8'd24;

    // complement mask of a base code
    localparam logic [1:0] BASE_COMP = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [9:0]  base_index;
        logic [1:0]  base;
        logic [10:0] length_a;
        logic [10:0] length_b;
        logic [9:0]  seed_pos_a;
        logic [9:0]  seed_pos_b;
        logic        rc_a;
        logic        rc_b;
        logic        same_read;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] a_begin;
        logic [9:0] a_end;
        logic [9:0] b_begin;
        logic [9:0] b_end;
        logic       reverse_overlap;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/sxo_store.sv
`default_nettype none

module sxo_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [1:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [1:0]         rdata
);

    logic [1:0] mem [DEPTH];

    // write one base
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/sxo_judge.sv
`default_nettype none

module sxo_judge #(
    parameter int CW = 12
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          valid,
    input  wire logic          force_short,
    input  wire logic [CW-1:0] pa,
    input  wire logic [CW-1:0] pb,
    input  wire logic [CW-1:0] len,
    input  wire logic [CW-1:0] la,
    input  wire logic [CW-1:0] lb,
    input  wire logic          rev,
    input  wire logic          same,
    input  wire logic [10:0]   min_overlap,
    output logic               result_valid,
    output sxo_pkg::result_t   result
);

    logic          s1_valid_reg;
    logic          s1_short_reg;
    logic [CW-1:0] s1_pa_reg;
    logic [CW-1:0] s1_pb_reg;
    logic [CW-1:0] s1_ae_reg;
    logic [CW-1:0] s1_be_reg;
    logic [CW-1:0] s1_lam1_reg;
    logic [CW-1:0] s1_lbm1_reg;
    logic          s1_rev_reg;
    logic          s1_same_reg;

    logic             out_valid_reg;
    sxo_pkg::result_t out_reg;
    sxo_pkg::result_t out_next;

    logic          a_head;
    logic          a_tail;
    logic          b_head;
    logic          b_tail;
    logic [2:0]    ext;
    logic [CW-1:0] bb2;
    logic [CW-1:0] be2;

    // stage 1: end coordinates and length check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid)
        begin
            s1_short_reg <= force_short || (len == '0) || (len < CW'(min_overlap));
            s1_pa_reg    <= pa;
            s1_pb_reg    <= pb;
            s1_ae_reg    <= pa + len - CW'(1);
            s1_be_reg    <= pb + len - CW'(1);
            s1_lam1_reg  <= la - CW'(1);
            s1_lbm1_reg  <= lb - CW'(1);
            s1_rev_reg   <= rev;
            s1_same_reg  <= same;
        end
    end

    // stage 2: read ends touched and overlap class
    always_comb
    begin
        a_head = (s1_pa_reg == '0);
        a_tail = (s1_ae_reg == s1_lam1_reg);
        b_head = (s1_pb_reg == '0);
        b_tail = (s1_be_reg == s1_lbm1_reg);
        ext    = {2'b00, a_head} + {2'b00, a_tail} + {2'b00, b_head} + {2'b00, b_tail};
        bb2    = s1_rev_reg ? (s1_lbm1_reg - s1_be_reg) : s1_pb_reg;
        be2    = s1_rev_reg ? (s1_lbm1_reg - s1_pb_reg) : s1_be_reg;

        out_next = '0;
        priority if (s1_short_reg)
        begin
            out_next.status = sxo_pkg::ST_TOO_SHORT;
        end
        else if (ext < 3'd2)
        begin
            out_next.status = sxo_pkg::ST_FEW_ENDS;
        end
        else if (s1_same_reg && (s1_pa_reg == s1_pb_reg) && (s1_ae_reg == s1_be_reg))
        begin
            out_next.status = sxo_pkg::ST_SAME_REG;
        end
        else if (a_head && (bb2 == '0) && (ext < 3'd3))
        begin
            out_next.status = sxo_pkg::ST_PREFIX;
        end
        else if (a_tail && (be2 == s1_lbm1_reg) && (ext < 3'd3))
        begin
            out_next.status = sxo_pkg::ST_SUFFIX;
        end
        else
        begin
            out_next.status          = sxo_pkg::ST_ACCEPTED;
            out_next.a_begin         = s1_pa_reg[9:0];
            out_next.a_end           = s1_ae_reg[9:0];
            out_next.b_begin         = s1_pb_reg[9:0];
            out_next.b_end           = s1_be_reg[9:0];
            out_next.reverse_overlap = s1_rev_reg;
        end
    end

    // hold the result for its strobe cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// File: hdl/seed_extend_overlap_check.sv
`default_nettype none

// Exact-seed extension and read-overlap test. A load command (start high while
// busy is low) writes one 2-bit base into store A or B, so a read streams in at
// one base per cycle while no evaluate holds busy high. An evaluate command
// raises busy and walks both stores outward from the seed, first left and then
// right: the stores have a registered read port, and each step issues an
// address and then compares the returned bases. No extension is walked when the
// seed lies outside a read. Exactly one result appears for each evaluate, on
// result with result_valid high for one cycle; it cannot be held off, and busy
// drops on the cycle after it. Loads never produce a result. Configuration must
// be written through cfg_we/cfg_index/cfg_data only while busy is low; the block
// itself does not enforce this.
module seed_extend_overlap_check #(
    parameter int MAX_READ_BASES = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire sxo_pkg::item_t  item,
    output logic                 result_valid,
    output sxo_pkg::result_t     result,
    input  wire logic            cfg_we,
    input  wire logic            cfg_index,
    input  wire logic [10:0]     cfg_data
);

    localparam int AW = $clog2(MAX_READ_BASES);
    localparam int PW = (AW > 10) ? AW : 10;
    localparam int CW = PW + 2;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_READ_BASES);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SETUP1 = 4'd1;
    localparam logic [3:0] S_SETUP2 = 4'd2;
    localparam logic [3:0] S_LISSUE = 4'd3;
    localparam logic [3:0] S_LCMP   = 4'd4;
    localparam logic [3:0] S_RISSUE = 4'd5;
    localparam logic [3:0] S_RCMP   = 4'd6;
    localparam logic [3:0] S_FIN    = 4'd7;
    localparam logic [3:0] S_JUDGE  = 4'd8;
    localparam logic [3:0] S_WAIT   = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [10:0]   min_overlap_reg;
    logic [7:0]    seed_length_reg;

    logic [CW-1:0] la_reg, la_next;
    logic [CW-1:0] lb_reg, lb_next;
    logic [CW-1:0] pa_reg, pa_next;
    logic [CW-1:0] pb_reg, pb_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] end_a_reg, end_a_next;
    logic [CW-1:0] end_b_reg, end_b_next;
    logic [CW-1:0] lmax_reg, lmax_next;
    logic [CW-1:0] rmax_reg, rmax_next;
    logic [CW-1:0] le_reg, le_next;
    logic [CW-1:0] re_reg, re_next;
    logic          rev_reg, rev_next;
    logic          same_reg, same_next;
    logic          fail_reg, fail_next;

    logic          accept;
    logic          in_range;
    logic          we_a;
    logic          we_b;
    logic [CW-1:0] waddr_cw;
    logic [CW-1:0] raddr_a_cw;
    logic [CW-1:0] raddr_b_cw;
    logic [1:0]    rdata_a;
    logic [1:0]    rdata_b;
    logic          bases_match;
    logic [CW-1:0] room_a;
    logic [CW-1:0] room_b;
    logic [CW-1:0] la_in;
    logic [CW-1:0] lb_in;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // base loads
    assign waddr_cw = CW'(item.base_index);
    assign in_range = (waddr_cw < MAX_C);
    assign we_a     = accept && (item.command == sxo_pkg::CMD_LOAD_A) && in_range;
    assign we_b     = accept && (item.command == sxo_pkg::CMD_LOAD_B) && in_range;

    sxo_store #(
        .DEPTH (MAX_READ_BASES),
        .AW    (AW)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr_cw[AW-1:0]),
        .wdata (item.base),
        .raddr (raddr_a_cw[AW-1:0]),
        .rdata (rdata_a)
    );

    sxo_store #(
        .DEPTH (MAX_READ_BASES),
        .AW    (AW)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr_cw[AW-1:0]),
        .wdata (item.base),
        .raddr (raddr_b_cw[AW-1:0]),
        .rdata (rdata_b)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_overlap_reg <= sxo_pkg::MIN_OVERLAP_RESET;
            seed_length_reg <= sxo_pkg::SEED_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sxo_pkg::REG_MIN_OVERLAP: min_overlap_reg <= cfg_data;
                sxo_pkg::REG_SEED_LENGTH: seed_length_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // read addresses for the current extension step
    always_comb
    begin
        raddr_a_cw = '0;
        raddr_b_cw = '0;
        if (state_reg == S_LISSUE)
        begin
            raddr_a_cw = pa_reg - CW'(1) - le_reg;
            raddr_b_cw = rev_reg ? (end_b_reg + le_reg) : (pb_reg - CW'(1) - le_reg);
        end
        else
        begin
            raddr_a_cw = end_a_reg + re_reg;
            raddr_b_cw = rev_reg ? (pb_reg - CW'(1) - re_reg) : (end_b_reg + re_reg);
        end
    end

    assign bases_match = (rdata_a == (rdata_b ^ (rev_reg ? sxo_pkg::BASE_COMP : 2'b00)));
    assign room_a      = la_reg - end_a_reg;
    assign room_b      = lb_reg - end_b_reg;
    assign la_in       = (CW'(item.length_a) > MAX_C) ? MAX_C : CW'(item.length_a);
    assign lb_in       = (CW'(item.length_b) > MAX_C) ? MAX_C : CW'(item.length_b);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        la_next    = la_reg;
        lb_next    = lb_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        len_next   = len_reg;
        end_a_next = end_a_reg;
        end_b_next = end_b_reg;
        lmax_next  = lmax_reg;
        rmax_next  = rmax_reg;
        le_next    = le_reg;
        re_next    = re_reg;
        rev_next   = rev_reg;
        same_next  = same_reg;
        fail_next  = fail_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.command == sxo_pkg::CMD_EVAL))
                begin
                    la_next    = la_in;
                    lb_next    = lb_in;
                    pa_next    = CW'(item.seed_pos_a);
                    pb_next    = CW'(item.seed_pos_b);
                    len_next   = CW'(seed_length_reg);
                    // flipping a (reverse, forward) pair keeps the flags unequal
                    rev_next   = item.rc_a ^ item.rc_b;
                    same_next  = item.same_read;
                    le_next    = '0;
                    re_next    = '0;
                    state_next = S_SETUP1;
                end
            end
            S_SETUP1:
            begin
                end_a_next = pa_reg + len_reg;
                end_b_next = pb_reg + len_reg;
                state_next = S_SETUP2;
            end
            S_SETUP2:
            begin
                fail_next = (end_a_reg > la_reg) || (end_b_reg > lb_reg);
                if (rev_reg)
                begin
                    lmax_next = (room_b < pa_reg) ? room_b : pa_reg;
                    rmax_next = (pb_reg < room_a) ? pb_reg : room_a;
                end
                else
                begin
                    lmax_next = (pb_reg < pa_reg) ? pb_reg : pa_reg;
                    rmax_next = (room_b < room_a) ? room_b : room_a;
                end
                state_next = ((end_a_reg > la_reg) || (end_b_reg > lb_reg)) ? S_FIN : S_LISSUE;
            end
            S_LISSUE:
            begin
                state_next = (le_reg == lmax_reg) ? S_RISSUE : S_LCMP;
            end
            S_LCMP:
            begin
                if (bases_match)
                begin
                    le_next    = le_reg + CW'(1);
                    state_next = S_LISSUE;
                end
                else
                begin
                    state_next = S_RISSUE;
                end
            end
            S_RISSUE:
            begin
                state_next = (re_reg == rmax_reg) ? S_FIN : S_RCMP;
            end
            S_RCMP:
            begin
                if (bases_match)
                begin
                    re_next    = re_reg + CW'(1);
                    state_next = S_RISSUE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // move the seed start back over the extension
                pa_next    = pa_reg - le_reg;
                pb_next    = rev_reg ? (pb_reg - re_reg) : (pb_reg - le_reg);
                len_next   = len_reg + le_reg + re_reg;
                state_next = S_JUDGE;
            end
            S_JUDGE:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (result_valid)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        la_reg    <= la_next;
        lb_reg    <= lb_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        len_reg   <= len_next;
        end_a_reg <= end_a_next;
        end_b_reg <= end_b_next;
        lmax_reg  <= lmax_next;
        rmax_reg  <= rmax_next;
        le_reg    <= le_next;
        re_reg    <= re_next;
        rev_reg   <= rev_next;
        same_reg  <= same_next;
        fail_reg  <= fail_next;
    end

    // classify the extended overlap
    sxo_judge #(
        .CW (CW)
    ) u_judge (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (state_reg == S_JUDGE),
        .force_short  (fail_reg),
        .pa           (pa_reg),
        .pb           (pb_reg),
        .len          (len_reg),
        .la           (la_reg),
        .lb           (lb_reg),
        .rev          (rev_reg),
        .same         (same_reg),
        .min_overlap  (min_overlap_reg),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef ASSERT_OFF
    // a result only ends an evaluate
    a_result_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (state_reg == S_WAIT))
        else $error("result strobe outside the wait state");

    // an accepted evaluate starts the walk
    a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.command == sxo_pkg::CMD_EVAL)) |=> (state_reg == S_SETUP1))
        else $error("evaluate transfer did not start the sequencer");

    // every left compare follows its address issue
    a_lcmp_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LCMP) |-> ($past(state_reg) == S_LISSUE))
        else $error("left compare without a read issue");

    // extension never passes its limit
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_LISSUE) || (state_reg == S_LCMP)) |-> (le_reg <= lmax_reg))
        else $error("left extension passed its limit");

    a_right_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RISSUE) || (state_reg == S_RCMP)) |-> (re_reg <= rmax_reg))
        else $error("right extension passed its limit");
`endif

endmodule

`default_nettype wire

// File: verif/tb_seed_extend_overlap_check.sv
module tb_seed_extend_overlap_check;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int READ_BASES = 1024;
    localparam int FILL_BASES = 160;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int MIN_OVERLAP_LO = 16;
    localparam int MIN_OVERLAP_HI = 1024;
    localparam int SEED_LEN_LO = 16;
    localparam int SEED_LEN_HI = 128;
    localparam int RANDOM_ITEMS = 500;
    localparam int RANDOM_EVALS = 40;
    localparam int PRINT_CAP = 50;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    sxo_pkg::item_t cmd_bus = '0;
    logic result_valid;
    sxo_pkg::result_t result;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [10:0] cfg_data = '0;

    seed_extend_overlap_check #(.MAX_READ_BASES(READ_BASES)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(cmd_bus),
        .result_valid(result_valid),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mirror of the block state: stores updated at each accepted transfer, registers at each write
    bit [1:0] store_a_copy[READ_BASES];
    bit [1:0] store_b_copy[READ_BASES];
    int min_overlap_q = sxo_pkg::MIN_OVERLAP_RESET;
    int seed_length_q = sxo_pkg::SEED_LENGTH_RESET;

    // Read contents as planned by the stimulus generator
    bit [1:0] plan_a[READ_BASES];
    bit [1:0] plan_b[READ_BASES];

    // Length of the loaded run from base 0 in each store
    int written_a = 0;
    int written_b = 0;

    sxo_pkg::item_t pending_cmds[$];
    sxo_pkg::result_t expected_overlaps[$];

    int burst_left = 0;
    int idle_left = 0;
    int work_items = 0;
    int evals_queued = 0;
    int loads_taken = 0;
    int evals_checked = 0;
    int config_writes = 0;
    int mismatch_count = 0;
    int status_seen[8];

    // Extend the seed over the mirrored stores and classify the overlap
    function automatic sxo_pkg::result_t predict_overlap(sxo_pkg::item_t c);
        sxo_pkg::result_t r;
        int la, lb, pa, pb, span, lmax, rmax, le, re, ends, ae, be, bb2, be2;
        bit ra, rb, rev;
        r = '0;
        la = (c.length_a > READ_BASES) ? READ_BASES : int'(c.length_a);
        lb = (c.length_b > READ_BASES) ? READ_BASES : int'(c.length_b);
        pa = c.seed_pos_a;
        pb = c.seed_pos_b;
        ra = c.rc_a;
        rb = c.rc_b;
        span = seed_length_q;
        le = 0;
        re = 0;
        // treat (reverse, forward) as (forward, reverse)
        if (ra && !rb)
        begin
            ra = 1'b0;
            rb = 1'b1;
        end
        rev = ra ^ rb;
        if (pa + span > la || pb + span > lb)
        begin
            r.status = sxo_pkg::ST_TOO_SHORT;
            return r;
        end
        if (!rev)
        begin
            lmax = (pa < pb) ? pa : pb;
            while (le < lmax && store_a_copy[pa - 1 - le] == store_b_copy[pb - 1 - le])
                le++;
            rmax = la - (pa + span);
            if (lb - (pb + span) < rmax)
                rmax = lb - (pb + span);
            while (re < rmax &&
                   store_a_copy[pa + span + re] == store_b_copy[pb + span + re])
                re++;
            pa -= le;
            pb -= le;
        end
        else
        begin
            // B is walked in the opposite direction and complemented
            lmax = pa;
            if (lb - (pb + span) < lmax)
                lmax = lb - (pb + span);
            while (le < lmax && store_a_copy[pa - 1 - le] ==
                   (store_b_copy[pb + span + le] ^ sxo_pkg::BASE_COMP))
                le++;
            rmax = la - (pa + span);
            if (pb < rmax)
                rmax = pb;
            while (re < rmax && store_a_copy[pa + span + re] ==
                   (store_b_copy[pb - 1 - re] ^ sxo_pkg::BASE_COMP))
                re++;
            pa -= le;
            pb -= re;
        end
        span += le + re;
        if (span == 0 || span < min_overlap_q)
        begin
            r.status = sxo_pkg::ST_TOO_SHORT;
            return r;
        end
        ae = pa + span - 1;
        be = pb + span - 1;
        ends = int'(pa == 0) + int'(ae == la - 1) + int'(pb == 0) + int'(be == lb - 1);
        if (ends < 2)
        begin
            r.status = sxo_pkg::ST_FEW_ENDS;
            return r;
        end
        if (c.same_read && pa == pb && ae == be)
        begin
            r.status = sxo_pkg::ST_SAME_REG;
            return r;
        end
        // B coordinates in forward orientation for the prefix and suffix tests
        bb2 = rev ? (lb - 1) - be : pb;
        be2 = rev ? (lb - 1) - pb : be;
        if (pa == 0 && bb2 == 0 && ends < 3)
        begin
            r.status = sxo_pkg::ST_PREFIX;
            return r;
        end
        if (ae == la - 1 && be2 == lb - 1 && ends < 3)
        begin
            r.status = sxo_pkg::ST_SUFFIX;
            return r;
        end
        r.status = sxo_pkg::ST_ACCEPTED;
        r.a_begin = pa[9:0];
        r.a_end = ae[9:0];
        r.b_begin = pb[9:0];
        r.b_end = be[9:0];
        r.reverse_overlap = rev;
        return r;
    endfunction

    task automatic flag_mismatch(string what);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Driver: present queued commands in bursts, predict at each transfer
    always @(posedge clk)
    begin
        sxo_pkg::item_t next_cmd;
        logic next_start;
        sxo_pkg::item_t done_cmd;
        if (rst_n)
        begin
            next_start = start;
            next_cmd = cmd_bus;
            if (start && !busy)
            begin
                done_cmd = pending_cmds.pop_front();
                case (done_cmd.command)
                    sxo_pkg::CMD_LOAD_A:
                    begin
                        store_a_copy[done_cmd.base_index] = done_cmd.base;
                        loads_taken++;
                    end
                    sxo_pkg::CMD_LOAD_B:
                    begin
                        store_b_copy[done_cmd.base_index] = done_cmd.base;
                        loads_taken++;
                    end
                    sxo_pkg::CMD_EVAL:
                        expected_overlaps.insert(expected_overlaps.size(),
                                                 predict_overlap(done_cmd));
                    default: ;
                endcase
                next_start = 1'b0;
            end
            // hold a presented command until it transfers
            if (!next_start)
            begin
                if (idle_left > 0)
                    idle_left--;
                else if (pending_cmds.size() > 0)
                begin
                    next_start = 1'b1;
                    next_cmd = pending_cmds[0];
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ?
                                     $urandom_range(40, 120) : $urandom_range(1, 16);
                        idle_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            start <= next_start;
            cmd_bus <= next_cmd;
        end
    end

    // Monitor: compare each result with the oldest predicted overlap
    always @(posedge clk)
    begin
        sxo_pkg::result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_overlaps.size() == 0)
                flag_mismatch($sformatf("result with nothing pending: %p", result));
            else
            begin
                want = expected_overlaps.pop_front();
                if (result.status !== want.status)
                    flag_mismatch($sformatf("status got %0d want %0d",
                                            result.status, want.status));
                if (result.a_begin !== want.a_begin)
                    flag_mismatch($sformatf("a_begin got %0d want %0d",
                                            result.a_begin, want.a_begin));
                if (result.a_end !== want.a_end)
                    flag_mismatch($sformatf("a_end got %0d want %0d",
                                            result.a_end, want.a_end));
                if (result.b_begin !== want.b_begin)
                    flag_mismatch($sformatf("b_begin got %0d want %0d",
                                            result.b_begin, want.b_begin));
                if (result.b_end !== want.b_end)
                    flag_mismatch($sformatf("b_end got %0d want %0d",
                                            result.b_end, want.b_end));
                if (result.reverse_overlap !== want.reverse_overlap)
                    flag_mismatch($sformatf("reverse_overlap got %0d want %0d",
                                            result.reverse_overlap, want.reverse_overlap));
                status_seen[want.status]++;
                evals_checked++;
            end
        end
    end

    task automatic queue_load(logic [1:0] which, int idx, logic [1:0] b);
        sxo_pkg::item_t c;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        c = raw[$bits(sxo_pkg::item_t)-1:0];
        c.command = which;
        c.base_index = idx[9:0];
        c.base = b;
        if (which == sxo_pkg::CMD_LOAD_A)
        begin
            plan_a[idx] = b;
            if (idx == written_a)
                written_a++;
        end
        else
        begin
            plan_b[idx] = b;
            if (idx == written_b)
                written_b++;
        end
        pending_cmds.insert(pending_cmds.size(), c);
        work_items++;
    endtask

    task automatic queue_eval(int la, int lb, int pa, int pb, bit ra, bit rb, bit same);
        sxo_pkg::item_t c;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        c = raw[$bits(sxo_pkg::item_t)-1:0];
        c.command = sxo_pkg::CMD_EVAL;
        c.length_a = la[10:0];
        c.length_b = lb[10:0];
        c.seed_pos_a = pa[9:0];
        c.seed_pos_b = pb[9:0];
        c.rc_a = ra;
        c.rc_b = rb;
        c.same_read = same;
        pending_cmds.insert(pending_cmds.size(), c);
        work_items++;
        evals_queued++;
    endtask

    // Fully random command: stray loads, unused command, arbitrary evaluates
    task automatic queue_noise();
        sxo_pkg::item_t c;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        c = raw[$bits(sxo_pkg::item_t)-1:0];
        if (c.command == sxo_pkg::CMD_EVAL)
        begin
            // keep the walk inside the loaded part of each store
            if (c.length_a > written_a)
                c.length_a = 11'(written_a);
            if (c.length_b > written_b)
                c.length_b = 11'(written_b);
            evals_queued++;
        end
        pending_cmds.insert(pending_cmds.size(), c);
        if (c.command != CMD_UNUSED)
            work_items++;
    endtask

    // Wait until every command has transferred and every result has come back
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || start || expected_overlaps.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic set_register(logic idx, int val);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[10:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == sxo_pkg::REG_MIN_OVERLAP)
            min_overlap_q = val[10:0];
        else
            seed_length_q = val[7:0];
        config_writes++;
    endtask

    function automatic int pick_offset(int room);
        case ($urandom_range(0, 2))
            0: return 0;
            1: return room;
            default: return $urandom_range(0, room);
        endcase
    endfunction

    // Two reads sharing a region, forward or reverse complement, then seeds in it
    task automatic build_pair();
        int la, lb, cap, k, s, t, o, n, fr;
        bit rev, twin;
        la = $urandom_range(seed_length_q, seed_length_q + 60);
        twin = ($urandom_range(0, 6) == 0);
        lb = twin ? la : $urandom_range(seed_length_q, seed_length_q + 60);
        rev = twin ? 1'b0 : 1'($urandom_range(0, 1));
        cap = (la < lb) ? la : lb;
        if (twin)
            k = la;
        else if ($urandom_range(0, 3) == 0)
            k = cap;
        else
            k = $urandom_range(seed_length_q, cap);
        s = twin ? 0 : pick_offset(la - k);
        t = twin ? 0 : pick_offset(lb - k);
        for (n = 0; n < la; n++)
            plan_a[n] = 2'($urandom);
        for (n = 0; n < lb; n++)
            plan_b[n] = 2'($urandom);
        for (n = 0; n < k; n++)
            plan_b[t + n] = rev ? (plan_a[s + k - 1 - n] ^ sxo_pkg::BASE_COMP) :
                                  plan_a[s + n];
        for (n = 0; n < la; n++)
            queue_load(sxo_pkg::CMD_LOAD_A, n, plan_a[n]);
        for (n = 0; n < lb; n++)
            queue_load(sxo_pkg::CMD_LOAD_B, n, plan_b[n]);
        repeat ($urandom_range(4, 8))
        begin
            // perturb a base or two so that extensions stop short
            if ($urandom_range(0, 1) == 1)
            begin
                repeat ($urandom_range(1, 2))
                begin
                    if ($urandom_range(0, 1) == 1)
                        queue_load(sxo_pkg::CMD_LOAD_A, $urandom_range(0, la - 1),
                                   2'($urandom));
                    else
                        queue_load(sxo_pkg::CMD_LOAD_B, $urandom_range(0, lb - 1),
                                   2'($urandom));
                end
            end
            repeat ($urandom_range(2, 4))
            begin
                if ($urandom_range(0, 5) == 0)
                    queue_noise();
                else
                begin
                    o = $urandom_range(0, k - seed_length_q);
                    fr = $urandom_range(0, 1);
                    queue_eval(la, lb, s + o,
                               rev ? t + k - o - seed_length_q : t + o,
                               fr[0], rev ? !fr[0] : fr[0],
                               twin ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0));
                end
            end
        end
    endtask

    initial
    begin
        int i, scenario, items_mark, evals_mark, mo, sl;
        logic [1:0] b;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Fill the front of both stores with B a copy of A
        for (i = 0; i < FILL_BASES; i++)
        begin
            b = 2'($urandom);
            queue_load(sxo_pkg::CMD_LOAD_A, i, b);
            queue_load(sxo_pkg::CMD_LOAD_B, i, b);
        end
        queue_eval(160, 160, 100, 100, 1'b0, 1'b0, 1'b1);     // one region of one read
        queue_eval(160, 160, 100, 100, 1'b0, 1'b0, 1'b0);     // full length match
        queue_eval(2047, 1500, 1001, 990, 1'b1, 1'b1, 1'b0);  // lengths saturate
        queue_eval(160, 160, 136, 136, 1'b0, 1'b0, 1'b0);     // seed ends on last base
        queue_eval(160, 160, 137, 3, 1'b0, 1'b0, 1'b0);       // seed past end of A
        queue_eval(160, 160, 3, 159, 1'b0, 1'b0, 1'b0);       // seed past end of B
        queue_eval(160, 160, 80, 40, 1'b1, 1'b0, 1'b0);       // reverse/forward swapped
        queue_eval(160, 160, 80, 40, 1'b0, 1'b1, 1'b0);
        queue_eval(160, 160, 5, 100, 1'b0, 1'b0, 1'b0);       // seed bases differ
        queue_eval(0, 0, 0, 0, 1'b0, 1'b0, 1'b0);             // empty reads
        queue_eval(159, 80, 0, 0, 1'b0, 1'b0, 1'b0);
        queue_noise();
        begin
            sxo_pkg::item_t idle_cmd;
            idle_cmd = '1;
            idle_cmd.command = CMD_UNUSED;
            pending_cmds.insert(pending_cmds.size(), idle_cmd);
        end
        // break B at 100: shared prefix, then shared suffix
        queue_load(sxo_pkg::CMD_LOAD_B, 100, plan_a[100] ^ 2'd1);
        queue_eval(160, 160, 0, 0, 1'b0, 1'b0, 1'b0);
        queue_eval(160, 160, 120, 120, 1'b0, 1'b0, 1'b0);
        // break B at 30 too: overlap reaches no read end
        queue_load(sxo_pkg::CMD_LOAD_B, 30, plan_a[30] ^ 2'd2);
        queue_eval(160, 160, 50, 50, 1'b0, 1'b0, 1'b0);
        queue_load(sxo_pkg::CMD_LOAD_B, 100, plan_a[100]);
        queue_load(sxo_pkg::CMD_LOAD_B, 30, plan_a[30]);

        set_register(sxo_pkg::REG_MIN_OVERLAP, FILL_BASES);
        queue_eval(160, 160, 10, 10, 1'b0, 1'b0, 1'b0);
        queue_eval(159, 160, 10, 10, 1'b0, 1'b0, 1'b0);
        set_register(sxo_pkg::REG_SEED_LENGTH, SEED_LEN_HI);
        queue_eval(160, 160, 32, 32, 1'b0, 1'b0, 1'b0);
        queue_eval(160, 160, 33, 32, 1'b0, 1'b0, 1'b0);
        set_register(sxo_pkg::REG_MIN_OVERLAP, MIN_OVERLAP_LO);
        set_register(sxo_pkg::REG_SEED_LENGTH, SEED_LEN_LO);
        queue_eval(160, 160, 144, 144, 1'b1, 1'b1, 1'b0);

        // Random phase: retune, build a read pair, probe it
        items_mark = work_items;
        evals_mark = evals_queued;
        scenario = 0;
        while (work_items - items_mark < RANDOM_ITEMS ||
               evals_queued - evals_mark < RANDOM_EVALS)
        begin
            case (scenario % 6)
                0:
                begin
                    mo = sxo_pkg::MIN_OVERLAP_RESET;
                    sl = sxo_pkg::SEED_LENGTH_RESET;
                end
                1:
                begin
                    mo = MIN_OVERLAP_LO;
                    sl = SEED_LEN_LO;
                end
                2:
                begin
                    mo = MIN_OVERLAP_HI;
                    sl = $urandom_range(SEED_LEN_LO, 40);
                end
                3:
                begin
                    mo = $urandom_range(MIN_OVERLAP_LO, 200);
                    sl = SEED_LEN_HI;
                end
                4:
                begin
                    mo = $urandom_range(MIN_OVERLAP_LO, MIN_OVERLAP_HI);
                    sl = $urandom_range(SEED_LEN_LO, SEED_LEN_HI);
                end
                default:
                begin
                    mo = $urandom_range(MIN_OVERLAP_LO, 60);
                    sl = $urandom_range(SEED_LEN_LO, 48);
                end
            endcase
            set_register(sxo_pkg::REG_MIN_OVERLAP, mo);
            set_register(sxo_pkg::REG_SEED_LENGTH, sl);
            build_pair();
            scenario++;
        end

        wait_drained();
        $display("covered %0d base loads, %0d evaluations, %0d register writes, %0d read pairs",
                 loads_taken, evals_checked, config_writes, scenario);
        $display("outcomes: accepted %0d, short %0d, few ends %0d, same %0d, prefix %0d, suffix %0d",
                 status_seen[sxo_pkg::ST_ACCEPTED], status_seen[sxo_pkg::ST_TOO_SHORT],
                 status_seen[sxo_pkg::ST_FEW_ENDS], status_seen[sxo_pkg::ST_SAME_REG],
                 status_seen[sxo_pkg::ST_PREFIX], status_seen[sxo_pkg::ST_SUFFIX]);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #10ms;
        $display("timeout with %0d commands and %0d results outstanding",
                 pending_cmds.size(), expected_overlaps.size());
        $display("tb: failure");
        $finish;
    end

endmodule
